FILE: rtl/core/cstd_pkg.sv
// Shared types, codes and helpers for the core slot task dispatcher.
package cstd_pkg;

  localparam int CORES_DEF = 32;
  localparam int SLOTS_DEF = 2;
  localparam int TYPES_DEF = 2;
  localparam int TASKS_DEF = 4096;

  localparam int MASK_W     = 32;
  localparam int TASK_W     = 12;
  localparam int CORE_OUT_W = 5;
  localparam int SCAN_W     = 64;
  localparam int SCAN_IW    = 6;

  localparam logic OP_DISPATCH = 1'b0;
  localparam logic OP_COMPLETE = 1'b1;

  typedef enum logic [1:0] {
    STAT_DISPATCHED = 2'd0,
    STAT_DUPLICATE  = 2'd1,
    STAT_NO_CORE    = 2'd2,
    STAT_COMPLETION = 2'd3
  } status_t;

  typedef struct packed {
    logic              op;
    logic [TASK_W-1:0] task_id;
    logic              exec_type;
    logic              done_slot;
    logic [MASK_W-1:0] done_bits;
  } cmd_t;

  typedef struct packed {
    status_t               status;
    logic [TASK_W-1:0]     out_task;
    logic [CORE_OUT_W-1:0] core;
    logic                  slot;
    logic                  free_left;
    logic                  last;
  } result_t;

  // Update request to the free bitmap bank.
  typedef struct packed {
    logic alloc;
    logic release_bits;
    logic slot;
  } free_cmd_t;

  // What the free bitmap bank reports for the selected type.
  typedef struct packed {
    logic found;
    logic slot;
    logic any_free;
    logic left_after;
  } pick_t;

  // Index of the lowest set bit, zero when none is set.
  function automatic logic [SCAN_IW-1:0] lowest_set(input logic [SCAN_W-1:0] v);
    logic [SCAN_IW-1:0] idx;
    idx = '0;
    for (int i = SCAN_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = SCAN_IW'(i);
      end
    end
    return idx;
  endfunction

endpackage

FILE: rtl/core/cstd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cstd_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/cstd_free.sv
// Free-core bitmaps per task type and slot, with the lowest-free-core search.
module cstd_free #(
  parameter int CORES = cstd_pkg::CORES_DEF,
  parameter int SLOTS = cstd_pkg::SLOTS_DEF,
  parameter int TYPES = cstd_pkg::TYPES_DEF,
  localparam int CW  = (CORES > 1) ? $clog2(CORES) : 1,
  localparam int TYW = (TYPES > 1) ? $clog2(TYPES) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [TYW-1:0]      qtype,
  input  logic [CORES-1:0]    mask,
  input  logic [CORES-1:0]    bits,
  input  cstd_pkg::free_cmd_t cmd,
  output cstd_pkg::pick_t     pick,
  output logic [CW-1:0]       pick_core
);

  localparam int ROW_W = SLOTS * CORES;

  logic [ROW_W-1:0] row [TYPES];
  logic [ROW_W-1:0] usable;
  logic [ROW_W-1:0] taken;
  logic [ROW_W-1:0] row_rel;
  logic [SLOTS-1:0] slot_hit;
  logic [CORES-1:0] cand;
  logic             sel;

  always_comb begin
    usable = row[qtype] & {SLOTS{mask}};
    for (int s = 0; s < SLOTS; s++) begin
      slot_hit[s] = |usable[s*CORES +: CORES];
    end
    // The first slot that has a usable core wins.
    sel = 1'b0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (slot_hit[s]) begin
        sel = 1'(s);
      end
    end
    cand = '0;
    for (int s = 0; s < SLOTS; s++) begin
      if (int'(sel) == s) begin
        cand = usable[s*CORES +: CORES];
      end
    end
    pick_core = CW'(cstd_pkg::lowest_set(cstd_pkg::SCAN_W'(cand)));
    taken = ROW_W'(1) << (int'(sel) * CORES + int'(pick_core));
    row_rel = row[qtype];
    for (int s = 0; s < SLOTS; s++) begin
      if (int'(cmd.slot) == s) begin
        row_rel[s*CORES +: CORES] = row[qtype][s*CORES +: CORES] | bits;
      end
    end
    pick.found      = |slot_hit;
    pick.slot       = sel;
    pick.any_free   = |usable;
    pick.left_after = |(usable & ~taken);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int t = 0; t < TYPES; t++) begin
        row[t] <= '1;
      end
    end else if (cmd.alloc) begin
      row[qtype] <= row[qtype] & ~taken;
    end else if (cmd.release_bits) begin
      row[qtype] <= row_rel;
    end
  end

endmodule

FILE: rtl/core/core_slot_task_dispatcher_core.sv
// Core slot task dispatcher: top level with the command sequencer.
//
// A command beat is taken when start is high and busy is low; cmd.op selects
// a dispatch or a completion report. Each result appears on result for one
// cycle with strobe high; the receiver cannot hold results back.
// A dispatch first reads the task's seen bit from the task memory, then in
// ST_DISP picks the lowest free permitted core and updates the state. Its
// single result is registered there, and busy is low again when it appears.
// A completion with k done bits ORs them into the free bitmap at once, then
// reads the core-to-task map once per set bit, one bit per cycle; results
// stream out one per cycle, lowest core first, and the last is marked.
// Busy stays high until the last result is registered; a completion with no
// done bits does not leave the idle state and gives no result.
// The rate is set by the single read port of the core-to-task map.
// After reset the task memory is cleared one entry per cycle, so busy stays
// high until all TASKS entries (4096 by default) are clear, before the first command.
// The core mask is written through cfg_valid/cfg_data, ready at all times,
// and resets to all ones; write it only while the block is idle.
module core_slot_task_dispatcher_core #(
  parameter int CORES = cstd_pkg::CORES_DEF,
  parameter int SLOTS = cstd_pkg::SLOTS_DEF,
  parameter int TYPES = cstd_pkg::TYPES_DEF,
  parameter int TASKS = cstd_pkg::TASKS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  cstd_pkg::cmd_t                cmd,
  output logic                          strobe,
  output cstd_pkg::result_t             result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cstd_pkg::MASK_W-1:0]   cfg_data
);

  localparam int CW        = (CORES > 1) ? $clog2(CORES) : 1;
  localparam int TYW       = (TYPES > 1) ? $clog2(TYPES) : 1;
  localparam int TW        = $clog2(TASKS);
  localparam int EW        = ((TW > cstd_pkg::TASK_W) ? TW : cstd_pkg::TASK_W) + 1;
  localparam int MAP_DEPTH = TYPES * SLOTS * CORES;
  localparam int MAW       = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_DISP  = 4'b0100,
    ST_COMP  = 4'b1000
  } state_t;

  state_t st;

  logic [cstd_pkg::MASK_W-1:0] core_mask;
  logic [TW-1:0]               clr_cnt;
  logic [cstd_pkg::TASK_W-1:0] task_r;
  logic [TYW-1:0]              t_idx_r;
  logic                        t_ok_r;
  logic                        ds_r;
  logic [CORES-1:0]            pend;
  logic                        s1_vld;
  logic [CW-1:0]               s1_core;
  logic                        s1_last;
  logic                        s1_left;

  logic                        accept;
  logic                        t_in_ok;
  logic                        ds_in_ok;
  logic                        comp_ok;
  logic                        task_ok;
  logic                        id_ok;
  logic [CORES-1:0]            mask_ext;
  logic [CORES-1:0]            done_ext;
  logic [CORES-1:0]            pend_next;
  logic [CW-1:0]               pc;
  logic [TYW-1:0]              qtype;
  cstd_pkg::free_cmd_t         fcmd;
  cstd_pkg::pick_t             pick;
  logic [CW-1:0]               pick_core;
  cstd_pkg::result_t           res_next;
  logic                        strobe_next;

  logic                        seen_we;
  logic [TW-1:0]               seen_waddr;
  logic                        seen_wdata;
  logic                        seen_rd;
  logic                        map_we;
  logic [MAW-1:0]              map_waddr;
  logic [MAW-1:0]              map_raddr;
  logic [cstd_pkg::TASK_W-1:0] map_rd;

  assign cfg_ready = 1'b1;
  assign busy      = (st != ST_IDLE) || s1_vld;
  assign accept    = start && !busy;

  always_comb begin
    mask_ext = '0;
    done_ext = '0;
    for (int i = 0; i < CORES && i < cstd_pkg::MASK_W; i++) begin
      mask_ext[i] = core_mask[i];
      done_ext[i] = cmd.done_bits[i];
    end
  end

  always_comb begin
    t_in_ok   = int'(cmd.exec_type) < TYPES;
    ds_in_ok  = int'(cmd.done_slot) < SLOTS;
    comp_ok   = accept && (cmd.op == cstd_pkg::OP_COMPLETE) && t_in_ok && ds_in_ok;
    task_ok   = EW'(task_r) < EW'(TASKS);
    id_ok     = EW'(map_rd) < EW'(TASKS);
    pend_next = pend & (pend - CORES'(1));
    pc        = CW'(cstd_pkg::lowest_set(cstd_pkg::SCAN_W'(pend)));
    map_raddr = MAW'((int'(t_idx_r) * SLOTS + int'(ds_r)) * CORES + int'(pc));
    map_waddr = MAW'((int'(t_idx_r) * SLOTS + int'(pick.slot)) * CORES + int'(pick_core));

    if (st == ST_IDLE) begin
      qtype = t_in_ok ? TYW'(cmd.exec_type) : '0;
    end else begin
      qtype = t_idx_r;
    end

    fcmd              = '0;
    fcmd.release_bits = comp_ok;
    fcmd.slot         = cmd.done_slot;
    seen_we           = 1'b0;
    seen_waddr        = clr_cnt;
    seen_wdata        = 1'b0;
    map_we            = 1'b0;
    res_next          = result;
    strobe_next       = 1'b0;

    if (st == ST_CLEAR) begin
      seen_we = 1'b1;
    end

    if (st == ST_DISP) begin
      strobe_next       = 1'b1;
      res_next.out_task = task_r;
      res_next.core     = '0;
      res_next.slot     = 1'b0;
      res_next.last     = 1'b1;
      if (!task_ok || seen_rd) begin
        res_next.status    = cstd_pkg::STAT_DUPLICATE;
        res_next.free_left = t_ok_r && pick.any_free;
      end else if (t_ok_r && pick.found) begin
        fcmd.alloc         = 1'b1;
        map_we             = 1'b1;
        seen_we            = 1'b1;
        seen_waddr         = TW'(task_r);
        seen_wdata         = 1'b1;
        res_next.status    = cstd_pkg::STAT_DISPATCHED;
        res_next.core      = cstd_pkg::CORE_OUT_W'(pick_core);
        res_next.slot      = pick.slot;
        res_next.free_left = pick.left_after;
      end else begin
        res_next.status    = cstd_pkg::STAT_NO_CORE;
        res_next.free_left = t_ok_r && pick.any_free;
      end
    end

    // Second stage of a completion: the map entry read last cycle is here.
    if (s1_vld) begin
      strobe_next        = 1'b1;
      seen_we            = id_ok;
      seen_waddr         = TW'(map_rd);
      seen_wdata         = 1'b1;
      res_next.status    = cstd_pkg::STAT_COMPLETION;
      res_next.out_task  = map_rd;
      res_next.core      = cstd_pkg::CORE_OUT_W'(s1_core);
      res_next.slot      = ds_r;
      res_next.free_left = s1_left;
      res_next.last      = s1_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_CLEAR;
      clr_cnt   <= '0;
      strobe    <= 1'b0;
      s1_vld    <= 1'b0;
      core_mask <= '1;
    end else begin
      strobe <= strobe_next;
      s1_vld <= (st == ST_COMP);
      if (cfg_valid && cfg_ready) begin
        core_mask <= cfg_data;
      end
      unique case (st)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + TW'(1);
          if (clr_cnt == TW'(TASKS - 1)) begin
            st <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept && (cmd.op == cstd_pkg::OP_DISPATCH)) begin
            st <= ST_DISP;
          end else if (comp_ok && (done_ext != '0)) begin
            st <= ST_COMP;
          end
        end
        ST_DISP: begin
          st <= ST_IDLE;
        end
        ST_COMP: begin
          if (pend_next == '0) begin
            st <= ST_IDLE;
          end
        end
        default: begin
          st <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    result <= res_next;
    if (st == ST_IDLE && accept) begin
      task_r  <= cmd.task_id;
      t_idx_r <= qtype;
      t_ok_r  <= t_in_ok;
      ds_r    <= cmd.done_slot;
      pend    <= done_ext;
    end
    if (st == ST_COMP) begin
      pend    <= pend_next;
      s1_core <= pc;
      s1_last <= (pend_next == '0);
      s1_left <= pick.any_free;
    end
  end

  cstd_free #(
    .CORES (CORES),
    .SLOTS (SLOTS),
    .TYPES (TYPES)
  ) u_free (
    .clk       (clk),
    .rst       (rst),
    .qtype     (qtype),
    .mask      (mask_ext),
    .bits      (done_ext),
    .cmd       (fcmd),
    .pick      (pick),
    .pick_core (pick_core)
  );

  // One bit per task: set once the task has been dispatched or completed.
  cstd_ram #(
    .WIDTH (1),
    .DEPTH (TASKS)
  ) u_seen_ram (
    .clk   (clk),
    .we    (seen_we),
    .waddr (seen_waddr),
    .wdata (seen_wdata),
    .raddr (TW'(cmd.task_id)),
    .rdata (seen_rd)
  );

  cstd_ram #(
    .WIDTH (cstd_pkg::TASK_W),
    .DEPTH (MAP_DEPTH)
  ) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (task_r),
    .raddr (map_raddr),
    .rdata (map_rd)
  );

endmodule

FILE: verif/tb_core_slot_task_dispatcher_core.sv
// Self-checking testbench for the core slot task dispatcher: directed table, then random phases.
`timescale 1ns / 1ps

module tb_core_slot_task_dispatcher_core;

  localparam int NCORES        = cstd_pkg::CORES_DEF;
  localparam int NSLOTS        = cstd_pkg::SLOTS_DEF;
  localparam int NTYPES        = cstd_pkg::TYPES_DEF;
  localparam int NTASKS        = cstd_pkg::TASKS_DEF;
  localparam int LIMIT_CYCLES  = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_SHOWN     = 10;
  localparam int PHASE_ITEMS   = 40;

  typedef struct {
    bit                is_cfg;
    cstd_pkg::cmd_t    c;
    logic [31:0]       mask;
    bit                typed;
    cstd_pkg::result_t want;
  } row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  cstd_pkg::cmd_t    cmd = '0;
  logic              cfg_valid = 1'b0;
  logic [31:0]       cfg_data = '0;
  logic              busy;
  logic              strobe;
  logic              cfg_ready;
  cstd_pkg::result_t result;

  // Shadow state of the dispatcher.
  logic [31:0] mask_model;
  logic [31:0] free_map [NTYPES][NSLOTS];
  logic [31:0] map_written [NTYPES][NSLOTS];
  logic [11:0] task_of_core [NTYPES][NSLOTS][NCORES];
  bit          dispatched_ids [NTASKS];
  bit          completed_ids [NTASKS];

  cstd_pkg::result_t pending_results [$];
  cstd_pkg::result_t fresh_results [$];
  row_t              directed_rows [$];
  logic [11:0]       retry_ids [$];
  logic [11:0]       used_ids [$];
  cstd_pkg::result_t want_now;
  int                mismatches = 0;
  int                cycle_count = 0;

  core_slot_task_dispatcher_core u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .strobe    (strobe),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic cstd_pkg::result_t make_result(cstd_pkg::status_t st,
                                                    logic [11:0] tid, int core_idx,
                                                    logic sl, logic left, logic lst);
    cstd_pkg::result_t r;
    r.status    = st;
    r.out_task  = tid;
    r.core      = core_idx[4:0];
    r.slot      = sl;
    r.free_left = left;
    r.last      = lst;
    return r;
  endfunction

  function automatic logic type_has_free(logic ty);
    logic any;
    any = 1'b0;
    for (int s = 0; s < NSLOTS; s++) begin
      if ((free_map[ty][s] & mask_model) != 0) any = 1'b1;
    end
    return any;
  endfunction

  function automatic int first_core(logic [31:0] v);
    for (int i = 0; i < NCORES; i++) begin
      if (v[i]) return i;
    end
    return 0;
  endfunction

  // Applies one accepted command to the shadow state and lists the results it causes.
  task automatic predict_outcomes(cstd_pkg::cmd_t c);
    logic [31:0] avail;
    logic [31:0] done;
    logic        ty;
    logic        left;
    logic [11:0] tid;
    int          core_idx;
    fresh_results.delete();
    ty = c.exec_type;
    if (c.op == cstd_pkg::OP_DISPATCH) begin
      tid = c.task_id;
      if (dispatched_ids[tid] || completed_ids[tid]) begin
        fresh_results.push_back(make_result(cstd_pkg::STAT_DUPLICATE, tid, 0, 1'b0,
                                            type_has_free(ty), 1'b1));
        return;
      end
      for (int s = 0; s < NSLOTS; s++) begin
        avail = free_map[ty][s] & mask_model;
        if (avail != 0) begin
          core_idx = first_core(avail);
          task_of_core[ty][s][core_idx] = tid;
          map_written[ty][s][core_idx] = 1'b1;
          free_map[ty][s][core_idx] = 1'b0;
          dispatched_ids[tid] = 1'b1;
          fresh_results.push_back(make_result(cstd_pkg::STAT_DISPATCHED, tid, core_idx,
                                              s[0], type_has_free(ty), 1'b1));
          return;
        end
      end
      fresh_results.push_back(make_result(cstd_pkg::STAT_NO_CORE, tid, 0, 1'b0,
                                          type_has_free(ty), 1'b1));
    end else begin
      done = c.done_bits;
      free_map[ty][c.done_slot] = free_map[ty][c.done_slot] | done;
      left = type_has_free(ty);
      for (int k = 0; k < NCORES; k++) begin
        if (done[k]) begin
          tid = task_of_core[ty][c.done_slot][k];
          completed_ids[tid] = 1'b1;
          fresh_results.push_back(make_result(cstd_pkg::STAT_COMPLETION, tid, k,
                                              c.done_slot, left,
                                              (done >> (k + 1)) == 0));
        end
      end
    end
  endtask

  task automatic report_fault(string what, cstd_pkg::result_t want, cstd_pkg::result_t got);
    mismatches++;
    if (mismatches <= MAX_SHOWN) begin
      $display("%0t %s: expected st=%0d task=%h core=%0d slot=%0d left=%0d last=%0d",
               $time, what, want.status, want.out_task, want.core, want.slot,
               want.free_left, want.last);
      $display("%0t %s:   actual st=%0d task=%h core=%0d slot=%0d left=%0d last=%0d",
               $time, what, got.status, got.out_task, got.core, got.slot,
               got.free_left, got.last);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (pending_results.size() == 0) begin
        report_fault("unexpected result", '0, result);
      end else begin
        want_now = pending_results.pop_front();
        if (result.status !== want_now.status || result.out_task !== want_now.out_task ||
            result.core !== want_now.core || result.slot !== want_now.slot ||
            result.free_left !== want_now.free_left || result.last !== want_now.last) begin
          report_fault("result mismatch", want_now, result);
        end
      end
    end
  end

  // Drives one command beat after a random gap and records what it should cause.
  task automatic issue(cstd_pkg::cmd_t c, bit burst, bit typed, cstd_pkg::result_t want);
    int gap;
    gap = (burst && $urandom_range(0, 3) != 0) ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (busy);
    predict_outcomes(c);
    if (typed) begin
      pending_results.push_back(want);
    end else begin
      foreach (fresh_results[i]) pending_results.push_back(fresh_results[i]);
    end
    if (c.op == cstd_pkg::OP_DISPATCH) begin
      used_ids.push_back(c.task_id);
      if (fresh_results[0].status == cstd_pkg::STAT_NO_CORE) retry_ids.push_back(c.task_id);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_mask(logic [31:0] m);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    mask_model = m;
  endtask

  function automatic row_t dispatch_row(logic [11:0] tid, logic ty);
    row_t r;
    r.is_cfg      = 1'b0;
    r.c.op        = cstd_pkg::OP_DISPATCH;
    r.c.task_id   = tid;
    r.c.exec_type = ty;
    r.c.done_slot = 1'($urandom);
    r.c.done_bits = $urandom;
    r.mask        = '0;
    r.typed       = 1'b0;
    r.want        = '0;
    return r;
  endfunction

  function automatic row_t complete_row(logic ty, logic sl, logic [31:0] bits);
    row_t r;
    r = dispatch_row(12'($urandom), ty);
    r.c.op        = cstd_pkg::OP_COMPLETE;
    r.c.done_slot = sl;
    r.c.done_bits = bits;
    return r;
  endfunction

  function automatic row_t mask_row(logic [31:0] m);
    row_t r;
    r = dispatch_row('0, 1'b0);
    r.is_cfg = 1'b1;
    r.mask   = m;
    return r;
  endfunction

  function automatic row_t expecting(row_t r, cstd_pkg::status_t st, logic [11:0] tid,
                                     int core_idx, logic sl, logic left);
    r.typed = 1'b1;
    r.want  = make_result(st, tid, core_idx, sl, left, 1'b1);
    return r;
  endfunction

  initial begin : stimulus
    logic [31:0]    phase_masks [7];
    logic [31:0]    outstanding;
    logic [31:0]    done;
    cstd_pkg::cmd_t c;
    bit             burst;
    bit             found;
    int             roll;
    int             pick;
    int             first_pair;
    int             pair;
    logic           ty;
    logic           sl;

    mask_model = 32'hFFFF_FFFF;
    for (int t = 0; t < NTYPES; t++) begin
      for (int s = 0; s < NSLOTS; s++) begin
        free_map[t][s] = 32'hFFFF_FFFF;
        map_written[t][s] = '0;
      end
    end

    directed_rows.push_back(expecting(dispatch_row(12'h000, 1'b0),
                                      cstd_pkg::STAT_DISPATCHED, 12'h000, 0, 1'b0, 1'b1));
    directed_rows.push_back(expecting(dispatch_row(12'hFFF, 1'b1),
                                      cstd_pkg::STAT_DISPATCHED, 12'hFFF, 0, 1'b0, 1'b1));
    directed_rows.push_back(expecting(dispatch_row(12'h000, 1'b0),
                                      cstd_pkg::STAT_DUPLICATE, 12'h000, 0, 1'b0, 1'b1));
    directed_rows.push_back(expecting(dispatch_row(12'h555, 1'b0),
                                      cstd_pkg::STAT_DISPATCHED, 12'h555, 1, 1'b0, 1'b1));
    directed_rows.push_back(dispatch_row(12'hAAA, 1'b0));
    directed_rows.push_back(complete_row(1'b0, 1'b0, 32'h0000_0007));
    // A completed task is dropped just like one still running.
    directed_rows.push_back(expecting(dispatch_row(12'h555, 1'b0),
                                      cstd_pkg::STAT_DUPLICATE, 12'h555, 0, 1'b0, 1'b1));
    directed_rows.push_back(complete_row(1'b0, 1'b0, 32'h0000_0000));
    directed_rows.push_back(expecting(complete_row(1'b1, 1'b0, 32'h0000_0001),
                                      cstd_pkg::STAT_COMPLETION, 12'hFFF, 0, 1'b0, 1'b1));
    directed_rows.push_back(mask_row(32'h0000_0000));
    directed_rows.push_back(expecting(dispatch_row(12'h123, 1'b0),
                                      cstd_pkg::STAT_NO_CORE, 12'h123, 0, 1'b0, 1'b0));
    directed_rows.push_back(expecting(dispatch_row(12'hFFF, 1'b1),
                                      cstd_pkg::STAT_DUPLICATE, 12'hFFF, 0, 1'b0, 1'b0));
    directed_rows.push_back(mask_row(32'h8000_0001));
    directed_rows.push_back(dispatch_row(12'h123, 1'b0));
    directed_rows.push_back(dispatch_row(12'h124, 1'b0));
    directed_rows.push_back(dispatch_row(12'h125, 1'b0));
    directed_rows.push_back(dispatch_row(12'h126, 1'b0));
    directed_rows.push_back(expecting(dispatch_row(12'h127, 1'b0),
                                      cstd_pkg::STAT_NO_CORE, 12'h127, 0, 1'b0, 1'b0));
    directed_rows.push_back(complete_row(1'b0, 1'b1, 32'h8000_0001));
    directed_rows.push_back(dispatch_row(12'h127, 1'b0));
    directed_rows.push_back(mask_row(32'hFFFF_FFFF));
    // Cores 1 and 2 are already free here, so their old tasks are reported again.
    directed_rows.push_back(complete_row(1'b0, 1'b0, 32'h8000_0007));
    directed_rows.push_back(dispatch_row(12'h800, 1'b1));

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        write_mask(directed_rows[i].mask);
      end else begin
        issue(directed_rows[i].c, 1'b0, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    phase_masks[0] = 32'hFFFF_FFFF;
    phase_masks[1] = $urandom;
    phase_masks[2] = 32'h8000_0000;
    phase_masks[3] = 32'h0000_FFFF;
    phase_masks[4] = 32'hFFFF_0000;
    phase_masks[5] = $urandom;
    phase_masks[6] = 32'hFFFF_FFFF;

    for (int phase = 0; phase < 7; phase++) begin
      write_mask(phase_masks[phase]);
      burst = (phase % 2 == 0);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        c.task_id   = 12'($urandom);
        c.exec_type = 1'($urandom);
        c.done_slot = 1'($urandom);
        c.done_bits = $urandom;
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
          c.op = cstd_pkg::OP_DISPATCH;
          pick = $urandom_range(0, 9);
          if (pick < 3 && retry_ids.size() > 0) begin
            c.task_id = retry_ids.pop_front();
          end else if (pick == 3 && used_ids.size() > 0) begin
            c.task_id = used_ids[$urandom_range(0, used_ids.size() - 1)];
          end
        end else begin
          // Only cores whose map entry has been written may be reported done.
          c.op = cstd_pkg::OP_COMPLETE;
          found = 1'b0;
          ty = 1'b0;
          sl = 1'b0;
          outstanding = '0;
          first_pair = $urandom_range(0, 3);
          for (int k = 0; k < 4; k++) begin
            pair = (first_pair + k) % 4;
            if (!found && (map_written[pair / 2][pair % 2] & ~free_map[pair / 2][pair % 2]) != 0)
            begin
              found = 1'b1;
              ty = pair[1];
              sl = pair[0];
              outstanding = map_written[ty][sl] & ~free_map[ty][sl];
            end
          end
          done = outstanding & $urandom;
          if (done == 0) done = outstanding;
          if (roll >= 95) done = '0;
          else if (roll >= 88) done = map_written[ty][sl] & $urandom;
          c.exec_type = ty;
          c.done_slot = sl;
          c.done_bits = done;
        end
        issue(c, burst, 1'b0, '0);
        if ((i == PHASE_ITEMS / 2 && phase % 2 == 1) || $urandom_range(0, 29) == 0) begin
          wait_drained();
        end
      end
    end

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/cstd_pkg.sv
rtl/core/cstd_ram.sv
rtl/core/cstd_free.sv
rtl/core/core_slot_task_dispatcher_core.sv
verif/tb_core_slot_task_dispatcher_core.sv
